FILE: rtl/ulafe_pkg.sv
// Shared types, codes and constants for the keyboard/border port block.
// No dependencies; imported by every module in rtl/.
package ulafe_pkg;

  // Request codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Machine models
  localparam logic [1:0] MODEL_ISSUE3 = 2'd0;
  localparam logic [1:0] MODEL_ISSUE2 = 2'd1;
  localparam logic [1:0] MODEL_PLUS3  = 2'd2;
  localparam logic [1:0] MODEL_ALT    = 2'd3;

  // Auto-typer states
  localparam logic [2:0] TYP_DONE    = 3'd0;
  localparam logic [2:0] TYP_SCAN    = 3'd1;
  localparam logic [2:0] TYP_KEY_J   = 3'd2;
  localparam logic [2:0] TYP_SHIFT_1 = 3'd3;
  localparam logic [2:0] TYP_SHIFT_2 = 3'd4;
  localparam logic [2:0] TYP_ENTER   = 3'd5;

  // Idle values and port addresses
  localparam logic [7:0] IDLE_HIGH    = 8'hff;
  localparam logic [7:0] IDLE_LOW     = 8'hbf;
  localparam logic [7:0] IDLE_ALT     = 8'h5f;
  localparam logic [7:0] PORT_NONE    = 8'hff;
  localparam logic [7:0] PORT_ROW_BF  = 8'hbf;
  localparam logic [7:0] PORT_ROW_7F  = 8'h7f;
  localparam logic [7:0] PORT_ROW_DF  = 8'hdf;
  localparam logic [7:0] ALL_ROWS     = 8'hff;
  localparam logic [3:0] WAIT_SCAN    = 4'd8;
  localparam logic [3:0] WAIT_SHIFT   = 4'd5;

  typedef struct packed {
    logic       read;
    logic       tick;
    logic [7:0] port_high;
  } typer_req_t;

  typedef struct packed {
    logic       read;
    logic       write;
    logic [7:0] write_data;
    logic [7:0] key_rows;
    logic       tape_mic;
  } port_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] border;
    logic [1:0] beeper_level;
    logic [7:0] last_written;
    logic       tape_level;
  } port_res_t;

  // One-hot row mark for a port address with a single zero bit
  function automatic logic [7:0] row_mark(input logic [7:0] hi);
    logic [7:0] m;
    case (hi)
      8'hfe:   m = 8'h01;
      8'hfd:   m = 8'h02;
      8'hfb:   m = 8'h04;
      8'hf7:   m = 8'h08;
      8'hef:   m = 8'h10;
      8'hdf:   m = 8'h20;
      8'hbf:   m = 8'h40;
      8'h7f:   m = 8'h80;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/ulafe_typer.sv
// Auto-typer: watches keyboard row scans and forces key bits low over frames.
// Depends on ulafe_pkg.
module ulafe_typer import ulafe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  typer_req_t req,
  output logic [7:0] key_mask
);

  logic [2:0] state, state_next;
  logic [2:0] next_state, next_state_next;
  logic [3:0] frame_wait, frame_wait_next;
  logic [7:0] rows_scanned, rows_scanned_next;
  logic [7:0] rows_or;

  always_comb begin
    state_next        = state;
    next_state_next   = next_state;
    frame_wait_next   = frame_wait;
    rows_scanned_next = rows_scanned;
    key_mask          = 8'hff;
    rows_or           = rows_scanned | row_mark(req.port_high);
    if (req.read) begin
      case (state)
        TYP_SCAN: begin
          if (req.port_high != PORT_NONE) begin
            rows_scanned_next = rows_or;
            if (rows_or == ALL_ROWS) begin
              next_state_next = TYP_KEY_J;
              frame_wait_next = WAIT_SCAN;
            end
          end
        end
        TYP_KEY_J: begin
          if (frame_wait == '0 && req.port_high == PORT_ROW_BF) begin
            key_mask[3]     = 1'b0;
            next_state_next = TYP_SHIFT_1;
          end
        end
        TYP_SHIFT_1, TYP_SHIFT_2: begin
          if (state == TYP_SHIFT_1 || frame_wait == '0) begin
            if (req.port_high == PORT_ROW_7F) key_mask[1] = 1'b0;
            else if (req.port_high == PORT_ROW_DF) key_mask[0] = 1'b0;
            if (state == TYP_SHIFT_1) begin
              next_state_next = TYP_SHIFT_2;
              frame_wait_next = WAIT_SHIFT;
            end else begin
              next_state_next = TYP_ENTER;
            end
          end
        end
        TYP_ENTER: begin
          if (req.port_high == PORT_ROW_BF) begin
            key_mask[0]     = 1'b0;
            next_state_next = TYP_DONE;
          end
        end
        default: ;
      endcase
    end else if (req.tick) begin
      rows_scanned_next = '0;
      state_next        = next_state;
      if (frame_wait != '0) frame_wait_next = frame_wait - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= TYP_DONE;
      next_state   <= TYP_SCAN;
      frame_wait   <= '0;
      rows_scanned <= '0;
    end else begin
      state        <= state_next;
      next_state   <= next_state_next;
      frame_wait   <= frame_wait_next;
      rows_scanned <= rows_scanned_next;
    end
  end

endmodule

FILE: rtl/ulafe_port.sv
// Port register file: machine model, last written byte and idle value,
// plus the result word for one request. Depends on ulafe_pkg.
module ulafe_port import ulafe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  port_req_t  req,
  input  logic [7:0] key_mask,
  output port_res_t  res
);

  logic [1:0] machine_model;
  logic [7:0] port_byte, port_byte_next;
  logic [7:0] idle_value, idle_value_next;

  always_comb begin
    port_byte_next  = port_byte;
    idle_value_next = idle_value;
    if (req.write) begin
      port_byte_next = req.write_data;
      case (machine_model)
        MODEL_ALT:    idle_value_next = IDLE_ALT;
        MODEL_PLUS3:  idle_value_next = IDLE_LOW;
        MODEL_ISSUE3: idle_value_next = req.write_data[4] ? IDLE_HIGH : IDLE_LOW;
        default:      idle_value_next = (req.write_data[4] | req.write_data[3]) ?
                                        IDLE_HIGH : IDLE_LOW;
      endcase
    end
  end

  // mic flips bit 6 of the read value
  always_comb begin
    res.read_data    = req.read ?
                       ((idle_value & key_mask & req.key_rows) ^ {1'b0, req.tape_mic, 6'b0}) :
                       8'h00;
    res.border       = port_byte_next[2:0];
    res.beeper_level = {port_byte_next[4], ~port_byte_next[3] | req.tape_mic};
    res.last_written = port_byte_next;
    res.tape_level   = port_byte_next[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      machine_model <= MODEL_ISSUE3;
      port_byte     <= '0;
      idle_value    <= IDLE_HIGH;
    end else begin
      if (cfg_we) machine_model <= cfg_wdata;
      port_byte  <= port_byte_next;
      idle_value <= idle_value_next;
    end
  end

endmodule

FILE: rtl/ula_port_fe_with_autotyper_unit.sv
// Top level of the keyboard/border port with auto-typer.
// Depends on ulafe_pkg, ulafe_typer and ulafe_port.
//
// Usage notes:
//  - Request channel: in_valid/in_stall with op, port_high, write_data,
//    key_rows and tape_mic. A request is taken at a clock edge where
//    in_valid is high and in_stall is low.
//  - Result channel: out_valid/out_stall with read_data, border,
//    beeper_level, last_written and tape_level; exactly one result per
//    request, in order. read_data is zero for anything but a port read.
//  - Config: cfg_we/cfg_wdata write machine_model; write only when idle.
//  - A taken request waits in the input register, then moves into the
//    result register. Throughput: one request per cycle while out_stall
//    is low, set by the single-pass logic between the two registers.
//  - Receiver stall: the result register holds; the input register keeps
//    one request, then in_stall rises until the result is taken.
//  - Reset (rst, synchronous): both registers empty, model 0, last byte 0,
//    idle value 0xff, auto-typer waiting for its first frame.
module ula_port_fe_with_autotyper_unit import ulafe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] port_high,
  input  logic [7:0] write_data,
  input  logic [7:0] key_rows,
  input  logic       tape_mic,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic [2:0] border,
  output logic [1:0] beeper_level,
  output logic [7:0] last_written,
  output logic       tape_level
);

  // Input register
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [7:0] s1_port_high;
  logic [7:0] s1_write_data;
  logic [7:0] s1_key_rows;
  logic       s1_tape_mic;

  logic       advance;   // s1 request moves into the result register
  logic       in_take;
  typer_req_t typer_req;
  port_req_t  port_req;
  port_res_t  res;
  logic [7:0] key_mask;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // State only moves when a request leaves the input register
  assign typer_req.read      = advance && (s1_op == OP_READ);
  assign typer_req.tick      = advance && (s1_op == OP_TICK);
  assign typer_req.port_high = s1_port_high;

  assign port_req.read       = typer_req.read;
  assign port_req.write      = advance && (s1_op == OP_WRITE);
  assign port_req.write_data = s1_write_data;
  assign port_req.key_rows   = s1_key_rows;
  assign port_req.tape_mic   = s1_tape_mic;

  ulafe_typer u_typer (
    .clk      (clk),
    .rst      (rst),
    .req      (typer_req),
    .key_mask (key_mask)
  );

  ulafe_port u_port (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (port_req),
    .key_mask  (key_mask),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op         <= op;
      s1_port_high  <= port_high;
      s1_write_data <= write_data;
      s1_key_rows   <= key_rows;
      s1_tape_mic   <= tape_mic;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data    <= res.read_data;
      border       <= res.border;
      beeper_level <= res.beeper_level;
      last_written <= res.last_written;
      tape_level   <= res.tape_level;
    end
  end

  // Checks
  a_stall_needs_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register empty after advance");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_take |=> s1_valid)
    else $error("input register empty after a request was taken");

  a_view_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (border == last_written[2:0] && tape_level == last_written[3]))
    else $error("result fields disagree with last written byte");

endmodule
